// ----- src/sbfd_pkg.sv -----
`default_nettype none

package sbfd_pkg;

   // field widths
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CHAN_W = 11;
   localparam int unsigned POS_W  = 5;

   // frame layout
   localparam int unsigned BODY_LEN     = 24;  // bytes after the start byte
   localparam int unsigned OUT_CHANS    = 8;   // channels carried on the result
   localparam int unsigned FS_POS       = 22;  // flag byte, body position
   localparam int unsigned FAILSAFE_BIT = 3;

   localparam logic [7:0] START_BYTE        = 8'h0F;
   localparam logic [7:0] END_BYTE          = 8'h00;
   localparam logic [7:0] GAP_TIMEOUT_RESET = 8'd8;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [CHAN_W-1:0] chan_type;
   typedef logic [BYTE_W-1:0] byte_type;

   // assembler to result stage
   typedef struct packed {
      logic done;      // good frame closed on this beat
      logic failsafe;  // flag bit of the frame
   } frame_ctl_type;

endpackage

`default_nettype wire

// ----- src/sbfd_if.sv -----
`default_nettype none

// received byte channel
interface sbfd_req_if import sbfd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type rx_byte;
   byte_type gap_ms;

   modport source (output valid, rx_byte, gap_ms, input ready);
   modport sink   (input valid, rx_byte, gap_ms, output ready);
endinterface

// decoded frame channel
interface sbfd_rsp_if import sbfd_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type chan_a;
   chan_type chan_b;
   chan_type chan_c;
   chan_type chan_d;
   chan_type chan_e;
   chan_type chan_f;
   chan_type chan_g;
   chan_type chan_h;
   logic     failsafe_flag;

   modport source (output valid, chan_a, chan_b, chan_c, chan_d, chan_e, chan_f,
                   chan_g, chan_h, failsafe_flag, input ready);
   modport sink   (input valid, chan_a, chan_b, chan_c, chan_d, chan_e, chan_f,
                   chan_g, chan_h, failsafe_flag, output ready);
endinterface

// timeout register write channel
interface sbfd_csr_if import sbfd_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type gap_timeout_ms;

   modport source (output valid, gap_timeout_ms, input ready);
   modport sink   (input valid, gap_timeout_ms, output ready);
endinterface

`default_nettype wire

// ----- src/sbfd_assembler.sv -----
`default_nettype none

module sbfd_assembler import sbfd_pkg::*; #(
   parameter int unsigned STORE_BYTES = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          beat,
   input  wire byte_type                      rx_byte,
   input  wire byte_type                      gap_ms,
   input  wire byte_type                      timeout,
   output frame_ctl_type                      ctl,
   output logic [STORE_BYTES*BYTE_W-1:0]      frame_bits
);

   logic     in_frame_ff, in_frame_in;
   pos_type  pos_ff, pos_in;
   byte_type store_ff [STORE_BYTES];
   logic     fs_ff;
   logic     live;
   logic     last;

   // a long gap drops back to hunting before the byte is looked at
   assign live = in_frame_ff && (gap_ms <= timeout);
   assign last = live && (pos_ff == pos_type'(BODY_LEN - 1));

   // frame state next value
   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      if (beat) begin
         if (!live) begin
            in_frame_in = (rx_byte == START_BYTE);
            pos_in      = '0;
         end else if (last) begin
            in_frame_in = 1'b0;
            pos_in      = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
      end
   end

   // capture only the bytes that carry output channels
   for (genvar i = 0; i < STORE_BYTES; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (beat && live && (pos_ff == pos_type'(i))) begin
            store_ff[i] <= rx_byte;
         end
      end
      assign frame_bits[i*BYTE_W +: BYTE_W] = store_ff[i];
   end

   // failsafe bit of the flag byte
   always_ff @(posedge clock) begin
      if (beat && live && (pos_ff == pos_type'(FS_POS))) begin
         fs_ff <= rx_byte[FAILSAFE_BIT];
      end
   end

   // end byte arrives live on the last beat
   assign ctl.done     = beat && last && (rx_byte == END_BYTE);
   assign ctl.failsafe = fs_ff;

endmodule

`default_nettype wire

// ----- src/sbfd_unpack.sv -----
`default_nettype none

module sbfd_unpack import sbfd_pkg::*; #(
   parameter int unsigned OUT_N       = 8,
   parameter int unsigned STORE_BYTES = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire frame_ctl_type                 ctl,
   input  wire logic [STORE_BYTES*BYTE_W-1:0] frame_bits,
   output logic                               room,
   sbfd_rsp_if.source                         rsp
);

   chan_type chan_in [OUT_CHANS];
   chan_type chan_ff [OUT_CHANS];
   logic     fs_ff;
   logic     valid_ff, valid_in;

   // 11-bit little-endian fields; unused channels read zero
   for (genvar k = 0; k < OUT_CHANS; k++) begin : g_chan
      if (k < OUT_N) begin : g_used
         assign chan_in[k] = frame_bits[k*CHAN_W +: CHAN_W];
      end else begin : g_zero
         assign chan_in[k] = '0;
      end
   end

   // result register
   assign valid_in = ctl.done || (valid_ff && !rsp.ready);
   assign room     = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.done) begin
         chan_ff <= chan_in;
         fs_ff   <= ctl.failsafe;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.chan_a        = chan_ff[0];
   assign rsp.chan_b        = chan_ff[1];
   assign rsp.chan_c        = chan_ff[2];
   assign rsp.chan_d        = chan_ff[3];
   assign rsp.chan_e        = chan_ff[4];
   assign rsp.chan_f        = chan_ff[5];
   assign rsp.chan_g        = chan_ff[6];
   assign rsp.chan_h        = chan_ff[7];
   assign rsp.failsafe_flag = fs_ff;

endmodule

`default_nettype wire

// ----- src/sbus_frame_decoder.sv -----
// SBUS frame decoder.
// req_bus carries one received byte per beat together with the gap in ms
// since the byte before it. rsp_bus carries one beat per good frame: the
// first eight 11-bit channels and the failsafe flag. csr_bus writes the
// gap timeout; it is always ready and should be written only while idle.
// A gap above the timeout sends the decoder back to hunting for the 0x0F
// start byte before the byte is handled; 24 body bytes follow, and a
// frame whose end byte is not 0x00 is dropped without a result.
// The result is valid the cycle after the end byte is accepted.
// Throughput: one byte per cycle while the single result register is not stalled.
// req_bus.ready drops only while a result waits and rsp_bus.ready is low.
// Reset: hunting, timeout back to 8 ms, no result pending.
// NUM_CHANNELS below 8 fixes the higher channel fields at zero.
`default_nettype none

module sbus_frame_decoder import sbfd_pkg::*; #(
   parameter int unsigned NUM_CHANNELS = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   sbfd_req_if.sink   req_bus,
   sbfd_rsp_if.source rsp_bus,
   sbfd_csr_if.sink   csr_bus
);

   localparam int unsigned OUT_N =
      (NUM_CHANNELS < OUT_CHANS) ? NUM_CHANNELS : OUT_CHANS;
   localparam int unsigned STORE_BYTES = (CHAN_W*OUT_N + BYTE_W - 1) / BYTE_W;

   byte_type                         gap_timeout_ff;
   logic                             room;
   logic                             beat;
   frame_ctl_type                    ctl;
   logic [STORE_BYTES*BYTE_W-1:0]    frame_bits;

   // timeout register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_timeout_ff <= GAP_TIMEOUT_RESET;
      end else if (csr_bus.valid) begin
         gap_timeout_ff <= csr_bus.gap_timeout_ms;
      end
   end

   // input handshake
   assign req_bus.ready = room;
   assign beat          = req_bus.valid && req_bus.ready;

   sbfd_assembler #(
      .STORE_BYTES (STORE_BYTES)
   ) u_assembler (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .rx_byte    (req_bus.rx_byte),
      .gap_ms     (req_bus.gap_ms),
      .timeout    (gap_timeout_ff),
      .ctl        (ctl),
      .frame_bits (frame_bits)
   );

   sbfd_unpack #(
      .OUT_N       (OUT_N),
      .STORE_BYTES (STORE_BYTES)
   ) u_unpack (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .frame_bits (frame_bits),
      .room       (room),
      .rsp        (rsp_bus)
   );

`ifndef SYNTHESIS
   // a frame only closes on an accepted end byte
   a_done_on_end: assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> (beat && (req_bus.rx_byte == END_BYTE)))
      else $error("frame closed without an accepted end byte");

   // a closed frame shows up on the result side next cycle
   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.done |=> rsp_bus.valid)
      else $error("decoded frame did not reach the result register");

   // a pending unaccepted result blocks the input
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("input taken while result register is full");
`endif

endmodule

`default_nettype wire

// ----- test/tb_sbus_frame_decoder.sv -----
`default_nettype none

module tb_sbus_frame_decoder;
   import sbfd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES     = 4;
   localparam int DRAIN_CYCLES      = 8;
   localparam int DRAIN_WAIT_MAX    = 2000;
   localparam int CYCLE_LIMIT       = 300000;
   localparam int FRAME_BYTE_TARGET = 1550;
   localparam int PHASE_BYTES       = 180;

   typedef enum logic {BEAT_BYTE, BEAT_CSR} beat_kind_type;
   typedef enum logic [1:0] {
      FRAME_GOOD, FRAME_BAD_END, FRAME_CUT_GAP, FRAME_SHORT
   } frame_kind_type;

   typedef struct packed {
      beat_kind_type kind;
      byte_type      data;   // received byte, or timeout value for a register write
      byte_type      gap;
   } tx_entry_type;

   typedef struct {
      chan_type chan [OUT_CHANS];
      logic     failsafe;
   } decoded_frame_type;

   logic clock;
   logic reset;

   sbfd_req_if req_bus ();
   sbfd_rsp_if rsp_bus ();
   sbfd_csr_if csr_bus ();

   sbus_frame_decoder u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // stimulus plan and the generator's view of the timeout
   tx_entry_type rx_plan [$];
   byte_type     plan_limit  = GAP_TIMEOUT_RESET;
   logic         plan_resync = 1'b0;
   int           plan_bytes  = 0;

   // decoder prediction state
   decoded_frame_type frames_due [$];
   byte_type          limit_model;
   logic              frame_open;
   pos_type           body_pos;
   byte_type          body_buf [BODY_LEN];

   int   error_count    = 0;
   int   bytes_taken    = 0;
   int   frames_checked = 0;
   int   csr_taken      = 0;
   int   cycle_count    = 0;
   int   quiet_cycles   = 0;
   int   send_hold      = 0;
   int   sink_stall     = 0;
   int   beats_sent     = 0;
   logic idle_off       = 1'b0;

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   function automatic int draw_wait();
      if (idle_off) return 0;
      return $urandom_range(0, 5);
   endfunction

   // expected decoder behavior for one received byte
   function automatic void decode_byte(input byte_type rx, input byte_type gap);
      decoded_frame_type          res;
      logic [BODY_LEN*BYTE_W-1:0] flat;
      if (gap > limit_model) frame_open = 1'b0;
      if (!frame_open) begin
         if (rx == START_BYTE) begin
            frame_open = 1'b1;
            body_pos   = '0;
         end
         return;
      end
      if (body_pos >= BODY_LEN) body_pos = '0;
      body_buf[body_pos] = rx;
      body_pos = body_pos + 1'b1;
      if (body_pos < BODY_LEN) return;
      frame_open = 1'b0;
      if (body_buf[BODY_LEN-1] != END_BYTE) return;
      // channels are packed LSB first from the first body byte
      for (int i = 0; i < BODY_LEN; i++) flat[i*BYTE_W +: BYTE_W] = body_buf[i];
      for (int k = 0; k < OUT_CHANS; k++) res.chan[k] = flat[k*CHAN_W +: CHAN_W];
      res.failsafe = body_buf[FS_POS][FAILSAFE_BIT];
      frames_due.push_back(res);
   endfunction

   // stimulus building
   function automatic byte_type gap_within();
      return byte_type'($urandom_range(0, 32'(plan_limit)));
   endfunction

   function automatic byte_type gap_beyond();
      return byte_type'($urandom_range(32'(plan_limit) + 1, 255));
   endfunction

   task automatic queue_byte(input byte_type b, input byte_type g);
      rx_plan.push_back('{BEAT_BYTE, b, g});
   endtask

   task automatic queue_timeout(input byte_type t);
      // leave the decoder hunting before the new setting takes hold
      if (plan_resync) queue_byte(END_BYTE, gap_beyond());
      plan_resync = 1'b0;
      rx_plan.push_back('{BEAT_CSR, t, 8'h00});
      plan_limit = t;
   endtask

   // fill < 0 gives random body bytes; start_gap < 0 picks the start gap here
   task automatic queue_frame(input frame_kind_type kind, input int fill, input int start_gap);
      byte_type body [BODY_LEN];
      byte_type sgap;
      int       cut;
      if (start_gap >= 0) sgap = byte_type'(start_gap);
      else if (plan_resync && plan_limit != 8'hFF) sgap = gap_beyond();
      else if ($urandom_range(0, 3) == 0) sgap = byte_type'($urandom_range(0, 255));
      else sgap = gap_within();
      for (int i = 0; i < BODY_LEN; i++)
         body[i] = (fill < 0) ? byte_type'($urandom_range(0, 255)) : byte_type'(fill);
      body[BODY_LEN-1] = (kind == FRAME_BAD_END) ? byte_type'($urandom_range(1, 255)) : END_BYTE;
      cut = (kind == FRAME_CUT_GAP || kind == FRAME_SHORT) ? $urandom_range(0, BODY_LEN-1)
                                                           : BODY_LEN;
      queue_byte(START_BYTE, sgap);
      for (int i = 0; i < cut; i++) queue_byte(body[i], gap_within());
      plan_bytes += cut + 1;
      // long gap mid-frame; the byte after it may open a new frame
      if (kind == FRAME_CUT_GAP) begin
         queue_byte($urandom_range(0, 1) ? START_BYTE : body[cut], gap_beyond());
         plan_bytes++;
      end
      plan_resync = (kind == FRAME_CUT_GAP || kind == FRAME_SHORT);
   endtask

   // stray bytes while hunting; a start byte among them needs a resync later
   task automatic queue_noise();
      int       n;
      byte_type b;
      n = $urandom_range(1, 8);
      repeat (n) begin
         b = byte_type'($urandom_range(0, 255));
         if (plan_limit == 8'hFF && b == START_BYTE) b = END_BYTE;
         queue_byte(b, byte_type'($urandom_range(0, 255)));
      end
      if (plan_limit != 8'hFF) plan_resync = 1'b1;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run control: plan, reset, drain, verdict
   initial begin : run_ctl
      int          phase;
      int          phase_end;
      int          r;
      int          fill;
      int          waited;
      byte_type    t;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.rx_byte        = '0;
      req_bus.gap_ms         = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.gap_timeout_ms = '0;
      rsp_bus.ready          = 1'b0;

      // directed frames at the reset timeout
      queue_frame(FRAME_GOOD, 8'hFF, -1);          // top channel values, failsafe set
      queue_frame(FRAME_GOOD, 8'h00, 255);         // long gap on the start byte itself
      queue_frame(FRAME_GOOD, START_BYTE, 0);      // start byte as ordinary body data
      queue_frame(FRAME_BAD_END, -1, -1);
      queue_frame(FRAME_CUT_GAP, -1, -1);
      queue_noise();
      queue_frame(FRAME_SHORT, -1, -1);
      queue_frame(FRAME_GOOD, -1, -1);

      // random phases over several timeout settings
      phase = 0;
      while (plan_bytes < FRAME_BYTE_TARGET) begin
         case (phase)
            0: t = 8'h00;
            1: t = 8'hFF;
            2: t = 8'h01;
            3: t = 8'hFE;
            default: t = byte_type'($urandom_range(0, 255));
         endcase
         queue_timeout(t);
         phase_end = plan_bytes + PHASE_BYTES;
         while (plan_bytes < phase_end) begin
            r    = $urandom_range(0, 9);
            fill = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00) : -1;
            case (r)
               6: queue_frame(FRAME_BAD_END, fill, -1);
               7: queue_frame(plan_limit != 8'hFF ? FRAME_CUT_GAP : FRAME_GOOD, fill, -1);
               8: queue_frame(plan_limit != 8'hFF ? FRAME_SHORT : FRAME_BAD_END, fill, -1);
               9: begin
                  queue_noise();
                  queue_frame(FRAME_GOOD, fill, -1);
               end
               default: queue_frame(FRAME_GOOD, fill, -1);
            endcase
         end
         phase++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (rx_plan.size() != 0 || req_bus.valid || csr_bus.valid) @(posedge clock);
      waited = 0;
      while (frames_due.size() != 0 && waited < DRAIN_WAIT_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frames_due.size() != 0)
         report_error($sformatf("%0d decoded frames never arrived", frames_due.size()));

      $display("covered %0d received bytes, %0d decoded frames, %0d timeout writes",
               bytes_taken, frames_checked, csr_taken);
      $display("%0d register phases, %0d mismatches", phase, error_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped by watchdog after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // byte and register driver
   always @(posedge clock) begin : drive_proc
      tx_entry_type nxt;
      logic         req_held;
      logic         csr_held;
      logic         req_v;
      logic         csr_v;
      req_held = req_bus.valid && !req_bus.ready;
      csr_held = csr_bus.valid && !csr_bus.ready;
      req_v    = req_held;
      csr_v    = csr_held;
      if (reset) begin
         req_v = 1'b0;
         csr_v = 1'b0;
         send_hold    <= 0;
         quiet_cycles <= 0;
      end else begin
         // now and then switch to a stretch with no idling on either side
         if (req_bus.valid && req_bus.ready) begin
            beats_sent++;
            if (beats_sent % 128 == 0) idle_off = ($urandom_range(0, 3) == 0);
         end
         quiet_cycles <= (req_bus.valid || csr_bus.valid) ? 0 : quiet_cycles + 1;
         if (!req_held && !csr_held) begin
            if (send_hold != 0) begin
               send_hold <= send_hold - 1;
            end else if (rx_plan.size() != 0) begin
               if (rx_plan[0].kind == BEAT_BYTE) begin
                  nxt = rx_plan.pop_front();
                  req_v = 1'b1;
                  req_bus.rx_byte <= nxt.data;
                  req_bus.gap_ms  <= nxt.gap;
                  send_hold       <= draw_wait();
               end else if (frames_due.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
                  // timeout write only once the decoder has gone quiet
                  nxt = rx_plan.pop_front();
                  csr_v = 1'b1;
                  csr_bus.gap_timeout_ms <= nxt.data;
                  send_hold              <= draw_wait();
               end
            end
         end
      end
      req_bus.valid <= req_v;
      csr_bus.valid <= csr_v;
   end

   // result sink with random stalls
   always @(posedge clock) begin : sink_proc
      int n;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         sink_stall    <= 0;
      end else if (rsp_bus.ready) begin
         if (rsp_bus.valid) begin
            n = draw_wait();
            if (n != 0) begin
               rsp_bus.ready <= 1'b0;
               sink_stall    <= n;
            end
         end
      end else begin
         if (sink_stall <= 1) rsp_bus.ready <= 1'b1;
         sink_stall <= sink_stall - 1;
      end
   end

   // monitor: predict from accepted beats, then check results
   always @(posedge clock) begin : monitor_proc
      decoded_frame_type want;
      chan_type          got [OUT_CHANS];
      if (reset) begin
         limit_model = GAP_TIMEOUT_RESET;
         frame_open  = 1'b0;
         body_pos    = '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            limit_model = csr_bus.gap_timeout_ms;
            csr_taken++;
         end
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.rx_byte, req_bus.gap_ms);
            bytes_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.chan_a, rsp_bus.chan_b, rsp_bus.chan_c, rsp_bus.chan_d,
                    rsp_bus.chan_e, rsp_bus.chan_f, rsp_bus.chan_g, rsp_bus.chan_h};
            if (frames_due.size() == 0) begin
               report_error($sformatf("decoded frame with none pending, chan_a %0d", got[0]));
            end else begin
               want = frames_due.pop_front();
               for (int k = 0; k < OUT_CHANS; k++)
                  if (got[k] !== want.chan[k])
                     report_error($sformatf("frame %0d channel %0d: got %0d expected %0d",
                                            frames_checked, k + 1, got[k], want.chan[k]));
               if (rsp_bus.failsafe_flag !== want.failsafe)
                  report_error($sformatf("frame %0d failsafe: got %b expected %b",
                                         frames_checked, rsp_bus.failsafe_flag,
                                         want.failsafe));
            end
            frames_checked++;
         end
      end
   end

endmodule

`default_nettype wire
